>>> hdl/msasp_pkg.sv
// Shared constants, substitution tables and residue classification for the sum-of-pairs scorer.
package msasp_pkg;

    localparam int MAX_SEQS       = 256;
    localparam int COUNT_W        = $clog2(MAX_SEQS + 1);
    localparam int RESIDUE_W      = 8;
    localparam int SCORE_CFG_W    = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 2;
    localparam int NUM_AA         = 20;
    localparam int CLS_W          = 5;
    localparam int SUB_W          = 6;
    localparam int MAX_SUB_ABS    = 17;
    localparam int MAX_CFG_ABS    = 1024;
    localparam int ACC_W          = $clog2(MAX_SEQS * MAX_SUB_ABS + 1) + 1;
    localparam int PAIR_ADD_W     = $clog2(MAX_SEQS * MAX_CFG_ABS + 1) + 1;
    localparam int COLUMN_TOTAL_W = 27;
    localparam int COLUMN_SCORE_W = 26;
    localparam int RANGE_SCORE_W  = 48;

    localparam logic [RESIDUE_W-1:0] GAP_CHAR  = 8'h2D;
    localparam logic [CLS_W-1:0]     CLS_GAP   = 5'd20;
    localparam logic [CLS_W-1:0]     CLS_OTHER = 5'd21;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MATRIX_SELECT     = 2'd0,
        REG_RESIDUE_GAP_SCORE = 2'd1,
        REG_GAP_GAP_SCORE     = 2'd2
    } cfg_index_t;

    typedef logic signed [SUB_W-1:0] sub_entry_t;
    typedef sub_entry_t sub_row_t [NUM_AA];
    typedef sub_row_t sub_table_t [NUM_AA];

    // Rows and columns follow the order A R N D C Q E G H I L K M F P S T W Y V.
    localparam sub_table_t BLOSUM62 = '{
        '{ 6'sd4, -6'sd1, -6'sd2, -6'sd2, 6'sd0, -6'sd1, -6'sd1, 6'sd0, -6'sd2, -6'sd1,
           -6'sd1, -6'sd1, -6'sd1, -6'sd2, -6'sd1, 6'sd1, 6'sd0, -6'sd3, -6'sd2, 6'sd0},
        '{-6'sd1, 6'sd5, 6'sd0, -6'sd2, -6'sd3, 6'sd1, 6'sd0, -6'sd2, 6'sd0, -6'sd3,
           -6'sd2, 6'sd2, -6'sd1, -6'sd3, -6'sd2, -6'sd1, -6'sd1, -6'sd3, -6'sd2, -6'sd3},
        '{-6'sd2, 6'sd0, 6'sd6, 6'sd1, -6'sd3, 6'sd0, 6'sd0, 6'sd0, 6'sd1, -6'sd3,
           -6'sd3, 6'sd0, -6'sd2, -6'sd3, -6'sd2, 6'sd1, 6'sd0, -6'sd4, -6'sd2, -6'sd3},
        '{-6'sd2, -6'sd2, 6'sd1, 6'sd6, -6'sd3, 6'sd0, 6'sd2, -6'sd1, -6'sd1, -6'sd3,
           -6'sd4, -6'sd1, -6'sd3, -6'sd3, -6'sd1, 6'sd0, -6'sd1, -6'sd4, -6'sd3, -6'sd3},
        '{ 6'sd0, -6'sd3, -6'sd3, -6'sd3, 6'sd9, -6'sd3, -6'sd4, -6'sd3, -6'sd3, -6'sd1,
           -6'sd1, -6'sd3, -6'sd1, -6'sd2, -6'sd3, -6'sd1, -6'sd1, -6'sd2, -6'sd2, -6'sd1},
        '{-6'sd1, 6'sd1, 6'sd0, 6'sd0, -6'sd3, 6'sd5, 6'sd2, -6'sd2, 6'sd0, -6'sd3,
           -6'sd2, 6'sd1, 6'sd0, -6'sd3, -6'sd1, 6'sd0, -6'sd1, -6'sd2, -6'sd1, -6'sd2},
        '{-6'sd1, 6'sd0, 6'sd0, 6'sd2, -6'sd4, 6'sd2, 6'sd5, -6'sd2, 6'sd0, -6'sd3,
           -6'sd3, 6'sd1, -6'sd2, -6'sd3, -6'sd1, 6'sd0, -6'sd1, -6'sd3, -6'sd2, -6'sd2},
        '{ 6'sd0, -6'sd2, 6'sd0, -6'sd1, -6'sd3, -6'sd2, -6'sd2, 6'sd6, -6'sd2, -6'sd4,
           -6'sd4, -6'sd2, -6'sd3, -6'sd3, -6'sd2, 6'sd0, -6'sd2, -6'sd2, -6'sd3, -6'sd3},
        '{-6'sd2, 6'sd0, 6'sd1, -6'sd1, -6'sd3, 6'sd0, 6'sd0, -6'sd2, 6'sd8, -6'sd3,
           -6'sd3, -6'sd1, -6'sd2, -6'sd1, -6'sd2, -6'sd1, -6'sd2, -6'sd2, 6'sd2, -6'sd3},
        '{-6'sd1, -6'sd3, -6'sd3, -6'sd3, -6'sd1, -6'sd3, -6'sd3, -6'sd4, -6'sd3, 6'sd4,
           6'sd2, -6'sd3, 6'sd1, 6'sd0, -6'sd3, -6'sd2, -6'sd1, -6'sd3, -6'sd1, 6'sd3},
        '{-6'sd1, -6'sd2, -6'sd3, -6'sd4, -6'sd1, -6'sd2, -6'sd3, -6'sd4, -6'sd3, 6'sd2,
           6'sd4, -6'sd2, 6'sd2, 6'sd0, -6'sd3, -6'sd2, -6'sd1, -6'sd2, -6'sd1, 6'sd1},
        '{-6'sd1, 6'sd2, 6'sd0, -6'sd1, -6'sd3, 6'sd1, 6'sd1, -6'sd2, -6'sd1, -6'sd3,
           -6'sd2, 6'sd5, -6'sd1, -6'sd3, -6'sd1, 6'sd0, -6'sd1, -6'sd3, -6'sd2, -6'sd2},
        '{-6'sd1, -6'sd1, -6'sd2, -6'sd3, -6'sd1, 6'sd0, -6'sd2, -6'sd3, -6'sd2, 6'sd1,
           6'sd2, -6'sd1, 6'sd5, 6'sd0, -6'sd2, -6'sd1, -6'sd1, -6'sd1, -6'sd1, 6'sd1},
        '{-6'sd2, -6'sd3, -6'sd3, -6'sd3, -6'sd2, -6'sd3, -6'sd3, -6'sd3, -6'sd1, 6'sd0,
           6'sd0, -6'sd3, 6'sd0, 6'sd6, -6'sd4, -6'sd2, -6'sd2, 6'sd1, 6'sd3, -6'sd1},
        '{-6'sd1, -6'sd2, -6'sd2, -6'sd1, -6'sd3, -6'sd1, -6'sd1, -6'sd2, -6'sd2, -6'sd3,
           -6'sd3, -6'sd1, -6'sd2, -6'sd4, 6'sd7, -6'sd1, -6'sd1, -6'sd4, -6'sd3, -6'sd2},
        '{ 6'sd1, -6'sd1, 6'sd1, 6'sd0, -6'sd1, 6'sd0, 6'sd0, 6'sd0, -6'sd1, -6'sd2,
           -6'sd2, 6'sd0, -6'sd1, -6'sd2, -6'sd1, 6'sd4, 6'sd1, -6'sd3, -6'sd2, -6'sd2},
        '{ 6'sd0, -6'sd1, 6'sd0, -6'sd1, -6'sd1, -6'sd1, -6'sd1, -6'sd2, -6'sd2, -6'sd1,
           -6'sd1, -6'sd1, -6'sd1, -6'sd2, -6'sd1, 6'sd1, 6'sd5, -6'sd2, -6'sd2, 6'sd0},
        '{-6'sd3, -6'sd3, -6'sd4, -6'sd4, -6'sd2, -6'sd2, -6'sd3, -6'sd2, -6'sd2, -6'sd3,
           -6'sd2, -6'sd3, -6'sd1, 6'sd1, -6'sd4, -6'sd3, -6'sd2, 6'sd11, 6'sd2, -6'sd3},
        '{-6'sd2, -6'sd2, -6'sd2, -6'sd3, -6'sd2, -6'sd1, -6'sd2, -6'sd3, 6'sd2, -6'sd1,
           -6'sd1, -6'sd2, -6'sd1, 6'sd3, -6'sd3, -6'sd2, -6'sd2, 6'sd2, 6'sd7, -6'sd1},
        '{ 6'sd0, -6'sd3, -6'sd3, -6'sd3, -6'sd1, -6'sd2, -6'sd2, -6'sd3, -6'sd3, 6'sd3,
           6'sd1, -6'sd2, 6'sd1, -6'sd1, -6'sd2, -6'sd2, 6'sd0, -6'sd3, -6'sd1, 6'sd4}
    };

    localparam sub_table_t PAM250 = '{
        '{ 6'sd2, -6'sd2, 6'sd0, 6'sd0, -6'sd2, 6'sd0, 6'sd0, 6'sd1, -6'sd1, -6'sd1,
           -6'sd2, -6'sd1, -6'sd1, -6'sd3, 6'sd1, 6'sd1, 6'sd1, -6'sd6, -6'sd3, 6'sd0},
        '{-6'sd2, 6'sd6, 6'sd0, -6'sd1, -6'sd4, 6'sd1, -6'sd1, -6'sd3, 6'sd2, -6'sd2,
           -6'sd3, 6'sd3, 6'sd0, -6'sd4, 6'sd0, 6'sd0, -6'sd1, 6'sd2, -6'sd4, -6'sd2},
        '{ 6'sd0, 6'sd0, 6'sd2, 6'sd2, -6'sd4, 6'sd1, 6'sd1, 6'sd0, 6'sd2, -6'sd2,
           -6'sd3, 6'sd1, -6'sd2, -6'sd3, 6'sd0, 6'sd1, 6'sd0, -6'sd4, -6'sd2, -6'sd2},
        '{ 6'sd0, -6'sd1, 6'sd2, 6'sd4, -6'sd5, 6'sd2, 6'sd3, 6'sd1, 6'sd1, -6'sd2,
           -6'sd4, 6'sd0, -6'sd3, -6'sd6, -6'sd1, 6'sd0, 6'sd0, -6'sd7, -6'sd4, -6'sd2},
        '{-6'sd2, -6'sd4, -6'sd4, -6'sd5, 6'sd12, -6'sd5, -6'sd5, -6'sd3, -6'sd3, -6'sd2,
           -6'sd6, -6'sd5, -6'sd5, -6'sd4, -6'sd3, 6'sd0, -6'sd2, -6'sd8, 6'sd0, -6'sd2},
        '{ 6'sd0, 6'sd1, 6'sd1, 6'sd2, -6'sd5, 6'sd4, 6'sd2, -6'sd1, 6'sd3, -6'sd2,
           -6'sd2, 6'sd1, -6'sd1, -6'sd5, 6'sd0, -6'sd1, -6'sd1, -6'sd5, -6'sd4, -6'sd2},
        '{ 6'sd0, -6'sd1, 6'sd1, 6'sd3, -6'sd5, 6'sd2, 6'sd4, 6'sd0, 6'sd1, -6'sd2,
           -6'sd3, 6'sd0, -6'sd2, -6'sd5, -6'sd1, 6'sd0, 6'sd0, -6'sd7, -6'sd4, -6'sd2},
        '{ 6'sd1, -6'sd3, 6'sd0, 6'sd1, -6'sd3, -6'sd1, 6'sd0, 6'sd5, -6'sd2, -6'sd3,
           -6'sd4, -6'sd2, -6'sd3, -6'sd5, 6'sd0, 6'sd1, 6'sd0, -6'sd7, -6'sd5, -6'sd1},
        '{-6'sd1, 6'sd2, 6'sd2, 6'sd1, -6'sd3, 6'sd3, 6'sd1, -6'sd2, 6'sd6, -6'sd2,
           -6'sd2, 6'sd0, -6'sd2, -6'sd2, 6'sd0, -6'sd1, -6'sd1, -6'sd3, 6'sd0, -6'sd2},
        '{-6'sd1, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd3, -6'sd2, 6'sd5,
           6'sd2, -6'sd2, 6'sd2, 6'sd1, -6'sd2, -6'sd1, 6'sd0, -6'sd5, -6'sd1, 6'sd4},
        '{-6'sd2, -6'sd3, -6'sd3, -6'sd4, -6'sd6, -6'sd2, -6'sd3, -6'sd4, -6'sd2, 6'sd2,
           6'sd6, -6'sd3, 6'sd4, 6'sd2, -6'sd3, -6'sd3, -6'sd2, -6'sd2, -6'sd1, 6'sd2},
        '{-6'sd1, 6'sd3, 6'sd1, 6'sd0, -6'sd5, 6'sd1, 6'sd0, -6'sd2, 6'sd0, -6'sd2,
           -6'sd3, 6'sd5, 6'sd0, -6'sd5, -6'sd1, 6'sd0, 6'sd0, -6'sd3, -6'sd4, -6'sd2},
        '{-6'sd1, 6'sd0, -6'sd2, -6'sd3, -6'sd5, -6'sd1, -6'sd2, -6'sd3, -6'sd2, 6'sd2,
           6'sd4, 6'sd0, 6'sd6, 6'sd0, -6'sd2, -6'sd2, -6'sd1, -6'sd4, -6'sd2, 6'sd2},
        '{-6'sd3, -6'sd4, -6'sd3, -6'sd6, -6'sd4, -6'sd5, -6'sd5, -6'sd5, -6'sd2, 6'sd1,
           6'sd2, -6'sd5, 6'sd0, 6'sd9, -6'sd5, -6'sd3, -6'sd3, 6'sd0, 6'sd7, -6'sd1},
        '{ 6'sd1, 6'sd0, 6'sd0, -6'sd1, -6'sd3, 6'sd0, -6'sd1, 6'sd0, 6'sd0, -6'sd2,
           -6'sd3, -6'sd1, -6'sd2, -6'sd5, 6'sd6, 6'sd1, 6'sd0, -6'sd6, -6'sd5, -6'sd1},
        '{ 6'sd1, 6'sd0, 6'sd1, 6'sd0, 6'sd0, -6'sd1, 6'sd0, 6'sd1, -6'sd1, -6'sd1,
           -6'sd3, 6'sd0, -6'sd2, -6'sd3, 6'sd1, 6'sd2, 6'sd1, -6'sd2, -6'sd3, -6'sd1},
        '{ 6'sd1, -6'sd1, 6'sd0, 6'sd0, -6'sd2, -6'sd1, 6'sd0, 6'sd0, -6'sd1, 6'sd0,
           -6'sd2, 6'sd0, -6'sd1, -6'sd3, 6'sd0, 6'sd1, 6'sd3, -6'sd5, -6'sd3, 6'sd0},
        '{-6'sd6, 6'sd2, -6'sd4, -6'sd7, -6'sd8, -6'sd5, -6'sd7, -6'sd7, -6'sd3, -6'sd5,
           -6'sd2, -6'sd3, -6'sd4, 6'sd0, -6'sd6, -6'sd2, -6'sd5, 6'sd17, 6'sd0, -6'sd6},
        '{-6'sd3, -6'sd4, -6'sd2, -6'sd4, 6'sd0, -6'sd4, -6'sd4, -6'sd5, 6'sd0, -6'sd1,
           -6'sd1, -6'sd4, -6'sd2, 6'sd7, -6'sd5, -6'sd3, -6'sd3, 6'sd0, 6'sd10, -6'sd2},
        '{ 6'sd0, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd1, -6'sd2, 6'sd4,
           6'sd2, -6'sd2, 6'sd2, -6'sd1, -6'sd1, -6'sd1, 6'sd0, -6'sd6, -6'sd2, 6'sd4}
    };

    // Maps an ASCII character to its table index, the gap class or the catch-all class.
    function automatic logic [CLS_W-1:0] classify(input logic [RESIDUE_W-1:0] ch);
        logic [CLS_W-1:0] cls;
        unique case (ch)
            8'h41:    cls = 5'd0;   // A
            8'h52:    cls = 5'd1;   // R
            8'h4E:    cls = 5'd2;   // N
            8'h44:    cls = 5'd3;   // D
            8'h43:    cls = 5'd4;   // C
            8'h51:    cls = 5'd5;   // Q
            8'h45:    cls = 5'd6;   // E
            8'h47:    cls = 5'd7;   // G
            8'h48:    cls = 5'd8;   // H
            8'h49:    cls = 5'd9;   // I
            8'h4C:    cls = 5'd10;  // L
            8'h4B:    cls = 5'd11;  // K
            8'h4D:    cls = 5'd12;  // M
            8'h46:    cls = 5'd13;  // F
            8'h50:    cls = 5'd14;  // P
            8'h53:    cls = 5'd15;  // S
            8'h54:    cls = 5'd16;  // T
            8'h57:    cls = 5'd17;  // W
            8'h59:    cls = 5'd18;  // Y
            8'h56:    cls = 5'd19;  // V
            GAP_CHAR: cls = CLS_GAP;
            default:  cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

>>> hdl/msasp_if.sv
// Valid/ready channel interfaces for residue items and column results.
interface msasp_item_if;
    import msasp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RESIDUE_W-1:0] residue;
    logic                 end_of_column;
    logic                 end_of_range;

    modport source (output valid, residue, end_of_column, end_of_range, input ready);
    modport sink   (input valid, residue, end_of_column, end_of_range, output ready);
endinterface

interface msasp_result_if;
    import msasp_pkg::*;

    logic                             valid;
    logic                             ready;
    logic signed [COLUMN_SCORE_W-1:0] column_score;
    logic signed [RANGE_SCORE_W-1:0]  range_score;
    logic                             range_done;

    modport source (output valid, column_score, range_score, range_done, input ready);
    modport sink   (input valid, column_score, range_score, range_done, output ready);
endinterface

>>> hdl/msa_sum_of_pairs_scorer_top.sv
// Top level of the sum-of-pairs column scorer: configuration, pipeline and result register.
//
// Residues enter on the items channel, one per transfer, column by column; end_of_column
// marks the last residue of a column and end_of_range marks a column that closes a range.
// Each column end produces one transfer on the results channel carrying the column score,
// the saturating range total including that column, and range_done; after range_done the
// total restarts from zero. Items without end_of_column produce no result.
// A residue is taken in every cycle while the input register is free. The pipeline has an input
// register, a pair-score register and a column-score register ahead of the result register.
// The pair score of each residue comes from the residue and gap counts and per-class table
// sums kept in flip-flops, so the per-residue update is small multiply-adds and no loop
// over earlier residues.
// When the results side stalls, the result register holds its value and each stage keeps
// moving until it meets a full stage; items are still taken while the stages behind the
// result register have room.
// Configuration is written through cfg_write, cfg_index and cfg_data while no item is in
// flight; the user must ensure it, the block does not. Reset clears the configuration, the
// counts, the column and range totals and all stage valid flags; no clearing pass is needed.
module msa_sum_of_pairs_scorer_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [msasp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [msasp_pkg::CFG_DATA_W-1:0]       cfg_data,
    msasp_item_if.sink                             items,
    msasp_result_if.source                         results
);
    import msasp_pkg::*;

    function automatic logic signed [COLUMN_TOTAL_W-1:0] sat_total(
        input logic signed [COLUMN_TOTAL_W:0] v);
        logic signed [COLUMN_TOTAL_W-1:0] r;
        if (v[COLUMN_TOTAL_W] != v[COLUMN_TOTAL_W-1])
        begin
            r = v[COLUMN_TOTAL_W] ? {1'b1, {(COLUMN_TOTAL_W - 1){1'b0}}}
                                  : {1'b0, {(COLUMN_TOTAL_W - 1){1'b1}}};
        end
        else
        begin
            r = v[COLUMN_TOTAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [COLUMN_SCORE_W-1:0] sat_column(
        input logic signed [COLUMN_TOTAL_W-1:0] v);
        logic signed [COLUMN_SCORE_W-1:0] r;
        if (v[COLUMN_TOTAL_W-1:COLUMN_SCORE_W-1] != {(COLUMN_TOTAL_W - COLUMN_SCORE_W + 1)
                                                    {v[COLUMN_TOTAL_W-1]}})
        begin
            r = v[COLUMN_TOTAL_W-1] ? {1'b1, {(COLUMN_SCORE_W - 1){1'b0}}}
                                    : {1'b0, {(COLUMN_SCORE_W - 1){1'b1}}};
        end
        else
        begin
            r = v[COLUMN_SCORE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [RANGE_SCORE_W-1:0] sat_range(
        input logic signed [RANGE_SCORE_W:0] v);
        logic signed [RANGE_SCORE_W-1:0] r;
        if (v[RANGE_SCORE_W] != v[RANGE_SCORE_W-1])
        begin
            r = v[RANGE_SCORE_W] ? {1'b1, {(RANGE_SCORE_W - 1){1'b0}}}
                                 : {1'b0, {(RANGE_SCORE_W - 1){1'b1}}};
        end
        else
        begin
            r = v[RANGE_SCORE_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic                          matrix_select_reg;
    logic signed [SCORE_CFG_W-1:0] residue_gap_score_reg;
    logic signed [SCORE_CFG_W-1:0] gap_gap_score_reg;

    // Input register.
    logic                 s1_valid_reg;
    logic [RESIDUE_W-1:0] s1_residue_reg;
    logic                 s1_eoc_reg;
    logic                 s1_eor_reg;

    // Pair-score register.
    logic                         s2_valid_reg;
    logic signed [PAIR_ADD_W-1:0] s2_add_reg;
    logic                         s2_eoc_reg;
    logic                         s2_eor_reg;

    // Column accumulation and finished column score.
    logic signed [COLUMN_TOTAL_W-1:0] column_total_reg;
    logic                             s3_valid_reg;
    logic signed [COLUMN_SCORE_W-1:0] s3_col_reg;
    logic                             s3_eor_reg;

    // Range total and result register.
    logic signed [RANGE_SCORE_W-1:0]  range_total_reg;
    logic                             out_valid_reg;
    logic signed [COLUMN_SCORE_W-1:0] out_col_reg;
    logic signed [RANGE_SCORE_W-1:0]  out_range_reg;
    logic                             out_done_reg;

    logic                             out_free;
    logic                             s3_free;
    logic                             s2_free;
    logic                             s1_free;
    logic                             adv1;
    logic                             adv2;
    logic                             adv3;
    logic signed [PAIR_ADD_W-1:0]     pair_add;
    logic signed [COLUMN_TOTAL_W-1:0] column_total_next;
    logic signed [COLUMN_SCORE_W-1:0] column_score_next;
    logic signed [RANGE_SCORE_W-1:0]  range_total_next;

    // Each stage moves forward when the stage after it is empty or moving.
    always_comb
    begin
        out_free = !out_valid_reg || results.ready;
        s3_free  = !s3_valid_reg || out_free;
        s2_free  = !s2_valid_reg || s3_free;
        s1_free  = !s1_valid_reg || s2_free;
        adv3     = s3_valid_reg && out_free;
        adv2     = s2_valid_reg && s3_free;
        adv1     = s1_valid_reg && s2_free;
    end

    assign items.ready = s1_free;

    msasp_pair_scorer u_pair_scorer
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (adv1),
        .residue           (s1_residue_reg),
        .end_of_column     (s1_eoc_reg),
        .matrix_select     (matrix_select_reg),
        .residue_gap_score (residue_gap_score_reg),
        .gap_gap_score     (gap_gap_score_reg),
        .pair_add          (pair_add)
    );

    always_comb
    begin
        column_total_next = sat_total((COLUMN_TOTAL_W + 1)'(column_total_reg)
                                      + (COLUMN_TOTAL_W + 1)'(s2_add_reg));
        column_score_next = sat_column(column_total_next);
        range_total_next  = sat_range((RANGE_SCORE_W + 1)'(range_total_reg)
                                      + (RANGE_SCORE_W + 1)'(s3_col_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_select_reg     <= 1'b0;
            residue_gap_score_reg <= '0;
            gap_gap_score_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MATRIX_SELECT:     matrix_select_reg     <= cfg_data[0];
                REG_RESIDUE_GAP_SCORE: residue_gap_score_reg <= cfg_data[SCORE_CFG_W-1:0];
                REG_GAP_GAP_SCORE:     gap_gap_score_reg     <= cfg_data[SCORE_CFG_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            column_total_reg <= '0;
            range_total_reg  <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= items.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= adv1;
            end
            // Only column ends travel past the column accumulator.
            if (s3_free)
            begin
                s3_valid_reg <= adv2 && s2_eoc_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= adv3;
            end
            if (adv2)
            begin
                column_total_reg <= s2_eoc_reg ? '0 : column_total_next;
            end
            if (adv3)
            begin
                range_total_reg <= s3_eor_reg ? '0 : range_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && items.valid)
        begin
            s1_residue_reg <= items.residue;
            s1_eoc_reg     <= items.end_of_column;
            s1_eor_reg     <= items.end_of_range;
        end
        if (adv1)
        begin
            s2_add_reg <= pair_add;
            s2_eoc_reg <= s1_eoc_reg;
            s2_eor_reg <= s1_eor_reg;
        end
        if (adv2 && s2_eoc_reg)
        begin
            s3_col_reg <= column_score_next;
            s3_eor_reg <= s2_eor_reg;
        end
        if (adv3)
        begin
            out_col_reg   <= s3_col_reg;
            out_range_reg <= range_total_next;
            out_done_reg  <= s3_eor_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.column_score = out_col_reg;
    assign results.range_score  = out_range_reg;
    assign results.range_done   = out_done_reg;

endmodule

>>> hdl/msasp_pair_scorer.sv
// Per-column class counts and the score a new residue adds against all earlier ones.
module msasp_pair_scorer
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     advance,
    input  logic [msasp_pkg::RESIDUE_W-1:0]          residue,
    input  logic                                     end_of_column,
    input  logic                                     matrix_select,
    input  logic signed [msasp_pkg::SCORE_CFG_W-1:0] residue_gap_score,
    input  logic signed [msasp_pkg::SCORE_CFG_W-1:0] gap_gap_score,
    output logic signed [msasp_pkg::PAIR_ADD_W-1:0]  pair_add
);
    import msasp_pkg::*;

    localparam int PROD_W = COUNT_W + 1 + SCORE_CFG_W;

    logic [COUNT_W-1:0]      seq_cnt_reg;
    logic [COUNT_W-1:0]      gap_cnt_reg;
    // Entry j holds the table score of class j against every amino acid seen so far.
    logic signed [ACC_W-1:0] blosum_acc_reg [NUM_AA];
    logic signed [ACC_W-1:0] pam_acc_reg [NUM_AA];

    logic [CLS_W-1:0]        cls;
    logic [CLS_W-1:0]        aa_idx;
    logic                    counted;
    logic                    is_gap;
    logic                    is_aa;
    logic [COUNT_W-1:0]      non_gap_cnt;
    logic signed [ACC_W-1:0] row_acc;
    logic signed [PROD_W-1:0] gap_prod;
    logic signed [PROD_W-1:0] non_gap_prod;
    logic signed [PROD_W:0]   add_full;

    always_comb
    begin
        cls          = classify(residue);
        counted      = seq_cnt_reg < COUNT_W'(MAX_SEQS);
        is_gap       = cls == CLS_GAP;
        is_aa        = cls < CLS_W'(NUM_AA);
        aa_idx       = is_aa ? cls : '0;
        non_gap_cnt  = seq_cnt_reg - gap_cnt_reg;
        row_acc      = matrix_select ? pam_acc_reg[aa_idx] : blosum_acc_reg[aa_idx];
        gap_prod     = PROD_W'($signed({1'b0, gap_cnt_reg}))
                       * PROD_W'(is_gap ? gap_gap_score : residue_gap_score);
        non_gap_prod = PROD_W'($signed({1'b0, non_gap_cnt})) * PROD_W'(residue_gap_score);

        if (!counted)
        begin
            add_full = '0;
        end
        else if (is_gap)
        begin
            add_full = (PROD_W + 1)'(gap_prod) + (PROD_W + 1)'(non_gap_prod);
        end
        else if (is_aa)
        begin
            add_full = (PROD_W + 1)'(gap_prod) + (PROD_W + 1)'(row_acc);
        end
        else
        begin
            add_full = (PROD_W + 1)'(gap_prod);
        end
    end

    // The magnitude is bounded by MAX_SEQS times the largest gap score.
    assign pair_add = add_full[PAIR_ADD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_cnt_reg <= '0;
            gap_cnt_reg <= '0;
            for (int j = 0; j < NUM_AA; j++)
            begin
                blosum_acc_reg[j] <= '0;
                pam_acc_reg[j]    <= '0;
            end
        end
        else if (advance)
        begin
            if (end_of_column)
            begin
                seq_cnt_reg <= '0;
                gap_cnt_reg <= '0;
                for (int j = 0; j < NUM_AA; j++)
                begin
                    blosum_acc_reg[j] <= '0;
                    pam_acc_reg[j]    <= '0;
                end
            end
            else if (counted)
            begin
                seq_cnt_reg <= seq_cnt_reg + COUNT_W'(1);
                if (is_gap)
                begin
                    gap_cnt_reg <= gap_cnt_reg + COUNT_W'(1);
                end
                if (is_aa)
                begin
                    for (int j = 0; j < NUM_AA; j++)
                    begin
                        blosum_acc_reg[j] <= blosum_acc_reg[j] + ACC_W'(BLOSUM62[j][aa_idx]);
                        pam_acc_reg[j]    <= pam_acc_reg[j] + ACC_W'(PAM250[j][aa_idx]);
                    end
                end
            end
        end
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the sum-of-pairs column scorer with a scoreboard class.
`timescale 1ns / 1ps

module testbench;
    import msasp_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          NUM_CLASSES  = 22;
    localparam logic [10:0] SCORE_MIN    = 11'h400;
    localparam logic [10:0] SCORE_MAX    = 11'h3FF;

    // Substitution tables, rows and columns in the order A R N D C Q E G H I L K M F P S T W Y V.
    localparam int BLOSUM_TAB [20][20] = '{
        '{ 4,-1,-2,-2, 0,-1,-1, 0,-2,-1,-1,-1,-1,-2,-1, 1, 0,-3,-2, 0},
        '{-1, 5, 0,-2,-3, 1, 0,-2, 0,-3,-2, 2,-1,-3,-2,-1,-1,-3,-2,-3},
        '{-2, 0, 6, 1,-3, 0, 0, 0, 1,-3,-3, 0,-2,-3,-2, 1, 0,-4,-2,-3},
        '{-2,-2, 1, 6,-3, 0, 2,-1,-1,-3,-4,-1,-3,-3,-1, 0,-1,-4,-3,-3},
        '{ 0,-3,-3,-3, 9,-3,-4,-3,-3,-1,-1,-3,-1,-2,-3,-1,-1,-2,-2,-1},
        '{-1, 1, 0, 0,-3, 5, 2,-2, 0,-3,-2, 1, 0,-3,-1, 0,-1,-2,-1,-2},
        '{-1, 0, 0, 2,-4, 2, 5,-2, 0,-3,-3, 1,-2,-3,-1, 0,-1,-3,-2,-2},
        '{ 0,-2, 0,-1,-3,-2,-2, 6,-2,-4,-4,-2,-3,-3,-2, 0,-2,-2,-3,-3},
        '{-2, 0, 1,-1,-3, 0, 0,-2, 8,-3,-3,-1,-2,-1,-2,-1,-2,-2, 2,-3},
        '{-1,-3,-3,-3,-1,-3,-3,-4,-3, 4, 2,-3, 1, 0,-3,-2,-1,-3,-1, 3},
        '{-1,-2,-3,-4,-1,-2,-3,-4,-3, 2, 4,-2, 2, 0,-3,-2,-1,-2,-1, 1},
        '{-1, 2, 0,-1,-3, 1, 1,-2,-1,-3,-2, 5,-1,-3,-1, 0,-1,-3,-2,-2},
        '{-1,-1,-2,-3,-1, 0,-2,-3,-2, 1, 2,-1, 5, 0,-2,-1,-1,-1,-1, 1},
        '{-2,-3,-3,-3,-2,-3,-3,-3,-1, 0, 0,-3, 0, 6,-4,-2,-2, 1, 3,-1},
        '{-1,-2,-2,-1,-3,-1,-1,-2,-2,-3,-3,-1,-2,-4, 7,-1,-1,-4,-3,-2},
        '{ 1,-1, 1, 0,-1, 0, 0, 0,-1,-2,-2, 0,-1,-2,-1, 4, 1,-3,-2,-2},
        '{ 0,-1, 0,-1,-1,-1,-1,-2,-2,-1,-1,-1,-1,-2,-1, 1, 5,-2,-2, 0},
        '{-3,-3,-4,-4,-2,-2,-3,-2,-2,-3,-2,-3,-1, 1,-4,-3,-2,11, 2,-3},
        '{-2,-2,-2,-3,-2,-1,-2,-3, 2,-1,-1,-2,-1, 3,-3,-2,-2, 2, 7,-1},
        '{ 0,-3,-3,-3,-1,-2,-2,-3,-3, 3, 1,-2, 1,-1,-2,-2, 0,-3,-1, 4}
    };

    localparam int PAM_TAB [20][20] = '{
        '{ 2,-2, 0, 0,-2, 0, 0, 1,-1,-1,-2,-1,-1,-3, 1, 1, 1,-6,-3, 0},
        '{-2, 6, 0,-1,-4, 1,-1,-3, 2,-2,-3, 3, 0,-4, 0, 0,-1, 2,-4,-2},
        '{ 0, 0, 2, 2,-4, 1, 1, 0, 2,-2,-3, 1,-2,-3, 0, 1, 0,-4,-2,-2},
        '{ 0,-1, 2, 4,-5, 2, 3, 1, 1,-2,-4, 0,-3,-6,-1, 0, 0,-7,-4,-2},
        '{-2,-4,-4,-5,12,-5,-5,-3,-3,-2,-6,-5,-5,-4,-3, 0,-2,-8, 0,-2},
        '{ 0, 1, 1, 2,-5, 4, 2,-1, 3,-2,-2, 1,-1,-5, 0,-1,-1,-5,-4,-2},
        '{ 0,-1, 1, 3,-5, 2, 4, 0, 1,-2,-3, 0,-2,-5,-1, 0, 0,-7,-4,-2},
        '{ 1,-3, 0, 1,-3,-1, 0, 5,-2,-3,-4,-2,-3,-5, 0, 1, 0,-7,-5,-1},
        '{-1, 2, 2, 1,-3, 3, 1,-2, 6,-2,-2, 0,-2,-2, 0,-1,-1,-3, 0,-2},
        '{-1,-2,-2,-2,-2,-2,-2,-3,-2, 5, 2,-2, 2, 1,-2,-1, 0,-5,-1, 4},
        '{-2,-3,-3,-4,-6,-2,-3,-4,-2, 2, 6,-3, 4, 2,-3,-3,-2,-2,-1, 2},
        '{-1, 3, 1, 0,-5, 1, 0,-2, 0,-2,-3, 5, 0,-5,-1, 0, 0,-3,-4,-2},
        '{-1, 0,-2,-3,-5,-1,-2,-3,-2, 2, 4, 0, 6, 0,-2,-2,-1,-4,-2, 2},
        '{-3,-4,-3,-6,-4,-5,-5,-5,-2, 1, 2,-5, 0, 9,-5,-3,-3, 0, 7,-1},
        '{ 1, 0, 0,-1,-3, 0,-1, 0, 0,-2,-3,-1,-2,-5, 6, 1, 0,-6,-5,-1},
        '{ 1, 0, 1, 0, 0,-1, 0, 1,-1,-1,-3, 0,-2,-3, 1, 2, 1,-2,-3,-1},
        '{ 1,-1, 0, 0,-2,-1, 0, 0,-1, 0,-2, 0,-1,-3, 0, 1, 3,-5,-3, 0},
        '{-6, 2,-4,-7,-8,-5,-7,-7,-3,-5,-2,-3,-4, 0,-6,-2,-5,17, 0,-6},
        '{-3,-4,-2,-4, 0,-4,-4,-5, 0,-1,-1,-4,-2, 7,-5,-3,-3, 0,10,-2},
        '{ 0,-2,-2,-2,-2,-2,-2,-1,-2, 4, 2,-2, 2,-1,-1,-1, 0,-6,-2, 4}
    };

    typedef struct {
        logic signed [COLUMN_SCORE_W-1:0] column_score;
        logic signed [RANGE_SCORE_W-1:0]  range_score;
        logic                             range_done;
    } column_result_t;

    class column_score_predictor;
        bit             use_pam;
        longint         residue_gap;
        longint         gap_gap;
        int unsigned    class_count [NUM_CLASSES];
        longint         column_sum;
        longint         range_sum;
        column_result_t expected_q [$];
        int             mismatches;
        string          letters;

        function new();
            letters     = "ARNDCQEGHILKMFPSTWYV";
            use_pam     = 1'b0;
            residue_gap = 0;
            gap_gap     = 0;
            column_sum  = 0;
            range_sum   = 0;
            mismatches  = 0;
            foreach (class_count[i]) class_count[i] = 0;
        endfunction

        function int class_of(logic [7:0] ch);
            if (ch == GAP_CHAR) return CLS_GAP;
            for (int i = 0; i < 20; i++)
                if (ch == letters[i]) return i;
            return CLS_OTHER;
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MATRIX_SELECT:     use_pam = data[0];
                REG_RESIDUE_GAP_SCORE: residue_gap = longint'($signed(data));
                REG_GAP_GAP_SCORE:     gap_gap = longint'($signed(data));
                default: ;
            endcase
        endfunction

        // Scores the new residue against everything already counted in the column.
        function void note_residue(logic [7:0] ch, logic eoc, logic eor);
            int             cls;
            longint         seen;
            longint         gaps;
            longint         add;
            longint         col;
            column_result_t res;
            cls  = class_of(ch);
            seen = 0;
            foreach (class_count[i]) seen += class_count[i];
            // Residues past the per-column limit are neither counted nor scored.
            if (seen < MAX_SEQS) begin
                gaps = class_count[CLS_GAP];
                if (cls == CLS_GAP)
                    add = gaps * gap_gap + (seen - gaps) * residue_gap;
                else begin
                    add = gaps * residue_gap;
                    if (cls != CLS_OTHER)
                        for (int i = 0; i < 20; i++)
                            add += longint'(class_count[i]) *
                                   (use_pam ? PAM_TAB[cls][i] : BLOSUM_TAB[cls][i]);
                end
                column_sum = clip(column_sum + add, COLUMN_TOTAL_W);
                class_count[cls]++;
            end
            if (!eoc) return;
            col       = clip(column_sum, COLUMN_SCORE_W);
            range_sum = clip(range_sum + col, RANGE_SCORE_W);
            res.column_score = col[COLUMN_SCORE_W-1:0];
            res.range_score  = range_sum[RANGE_SCORE_W-1:0];
            res.range_done   = eor;
            expected_q.push_back(res);
            foreach (class_count[i]) class_count[i] = 0;
            column_sum = 0;
            if (eor) range_sum = 0;
        endfunction

        function void check_result(logic signed [COLUMN_SCORE_W-1:0] col,
                                   logic signed [RANGE_SCORE_W-1:0] rng, logic done);
            column_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with none pending: column_score %0d range_score %0d",
                         $time, col, rng);
                return;
            end
            want = expected_q.pop_front();
            if (col !== want.column_score) begin
                mismatches++;
                $display("%0t: column_score expected %0d, got %0d",
                         $time, want.column_score, col);
            end
            if (rng !== want.range_score) begin
                mismatches++;
                $display("%0t: range_score expected %0d, got %0d",
                         $time, want.range_score, rng);
            end
            if (done !== want.range_done) begin
                mismatches++;
                $display("%0t: range_done expected %0b, got %0b",
                         $time, want.range_done, done);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     cycle_count = 0;
    int                     items_sent = 0;
    bit                     tx_idle;
    bit                     rx_idle;
    column_score_predictor  model;

    msasp_item_if   items_ch ();
    msasp_result_if results_ch ();

    msa_sum_of_pairs_scorer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_ch),
        .results   (results_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic int column_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 6);
        if (r < 95) return $urandom_range(7, 20);
        return $urandom_range(21, 60);
    endfunction

    function automatic logic [10:0] pick_score();
        logic [10:0] v;
        case ($urandom_range(0, 3))
            0:       v = SCORE_MIN;
            1:       v = SCORE_MAX;
            default: v = 11'($urandom_range(0, 2047));
        endcase
        return v;
    endfunction

    // Flavors: 0 mostly letters, 1 gap heavy, 2 arbitrary bytes, 3 gaps only.
    function automatic logic [7:0] pick_residue(int flavor);
        int r;
        r = $urandom_range(0, 99);
        case (flavor)
            0:
            begin
                if (r < 80) return model.letters[$urandom_range(0, 19)];
                if (r < 90) return GAP_CHAR;
                return 8'($urandom_range(0, 255));
            end
            1:       return (r < 60) ? GAP_CHAR : model.letters[$urandom_range(0, 19)];
            2:       return 8'($urandom_range(0, 255));
            default: return GAP_CHAR;
        endcase
    endfunction

    task automatic send_residue(input logic [7:0] ch, input logic eoc, input logic eor);
        int gap;
        gap = (tx_idle && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid         <= 1'b1;
        items_ch.residue       <= ch;
        items_ch.end_of_column <= eoc;
        items_ch.end_of_range  <= eor;
        do @(posedge clk); while (!items_ch.ready);
        model.note_residue(ch, eoc, eor);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eor);
        for (int i = 0; i < s.len(); i++)
            send_residue(s[i], i == s.len() - 1, (i == s.len() - 1) ? eor : 1'b0);
    endtask

    // Range-end marks on residues inside the column are noise the block must ignore.
    task automatic send_column(input int len, input int flavor, input bit close_range);
        for (int i = 0; i < len; i++)
            send_residue(pick_residue(flavor), i == len - 1,
                         (i == len - 1) ? close_range : ($urandom_range(0, 9) == 0));
    endtask

    task automatic drain_results();
        items_ch.valid <= 1'b0;
        while (model.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit sel, input logic [10:0] rgs, input logic [10:0] ggs);
        logic [CFG_DATA_W-1:0] sel_word;
        drain_results();
        sel_word = {10'($urandom_range(0, 1023)), sel};
        cfg_write <= 1'b1;
        cfg_index <= REG_MATRIX_SELECT;
        cfg_data  <= sel_word;
        @(posedge clk);
        model.set_register(REG_MATRIX_SELECT, sel_word);
        cfg_index <= REG_RESIDUE_GAP_SCORE;
        cfg_data  <= rgs;
        @(posedge clk);
        model.set_register(REG_RESIDUE_GAP_SCORE, rgs);
        cfg_index <= REG_GAP_GAP_SCORE;
        cfg_data  <= ggs;
        @(posedge clk);
        model.set_register(REG_GAP_GAP_SCORE, ggs);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_ch.valid && results_ch.ready)
                model.check_result(results_ch.column_score, results_ch.range_score,
                                   results_ch.range_done);
            if (stall_left > 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle && $urandom_range(0, 99) < 30)
            begin
                results_ch.ready <= 1'b0;
                stall_left = idle_len() - 1;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int start;
        bit sel;
        logic [10:0] rgs;
        logic [10:0] ggs;
        model = new();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_MATRIX_SELECT;
        cfg_data = '0;
        items_ch.valid = 1'b0;
        items_ch.residue = '0;
        items_ch.end_of_column = 1'b0;
        items_ch.end_of_range = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at their reset values.
        send_text("WW", 1'b0);
        send_text("A-R", 1'b1);

        configure(1'b0, SCORE_MIN, SCORE_MAX);
        send_text("-", 1'b0);
        send_text("--C", 1'b0);
        // Lower-case and non-amino letters fall into the catch-all class.
        send_text("zAB", 1'b1);
        send_residue(8'h00, 1'b0, 1'b0);
        send_residue(8'hFF, 1'b0, 1'b1);
        send_residue(GAP_CHAR, 1'b1, 1'b0);
        send_residue("Y", 1'b0, 1'b1);
        send_residue("V", 1'b1, 1'b1);

        configure(1'b1, SCORE_MAX, SCORE_MIN);
        send_text("CCWW", 1'b1);
        send_text("-M", 1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            sel = 1'($urandom_range(0, 1));
            rgs = pick_score();
            ggs = pick_score();
            if (phase == 2)
            begin
                sel = 1'b0;
                rgs = SCORE_MIN;
                ggs = SCORE_MIN;
            end
            else if (phase == 5)
            begin
                sel = 1'b1;
                rgs = SCORE_MAX;
                ggs = SCORE_MAX;
            end
            configure(sel, rgs, ggs);
            tx_idle = (phase % 3 != 0);
            rx_idle = (phase % 4 != 1);
            start = items_sent;
            // Columns longer than the residue limit, with scores near the extremes.
            if (phase == 2)
                send_column($urandom_range(257, 270), 3, 1'b1);
            else if (phase == 5)
                send_column($urandom_range(257, 270), 1, 1'b1);
            while (items_sent - start < 90)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    send_column(column_len(), 1, $urandom_range(0, 3) == 0);
                    2, 3:    send_column(column_len(), 2, $urandom_range(0, 3) == 0);
                    default: send_column(column_len(), 0, $urandom_range(0, 3) == 0);
                endcase
            end
        end

        drain_results();
        if (model.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
